// File: src/bounded_list_engine_top_assert.svh
// Assertion macros used by the list engine top module.
`ifndef BOUNDED_LIST_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define BLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ble_pkg.sv
// Package with the types, codes and defaults of the bounded list engine.
`default_nettype none
package ble_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 7;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_WAIT,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// File: src/ble_req_if.sv
// Request channel interface of the bounded list engine.
`default_nettype none
interface ble_req_if;
    logic                                   valid;
    logic                                   ready;
    logic        [ble_pkg::ACTION_W-1:0]    action;
    logic signed [ble_pkg::VALUE_W-1:0]     value;
    logic        [ble_pkg::POSITION_W-1:0]  position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink (input valid, input action, input value, input position, output ready);
endinterface
`default_nettype wire

// File: src/ble_rsp_if.sv
// Response channel interface of the bounded list engine.
`default_nettype none
interface ble_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [ble_pkg::STATUS_W-1:0]  status;
    logic        [ble_pkg::COUNT_W-1:0]   element_count;
    logic signed [ble_pkg::VALUE_W-1:0]   front_value;
    logic signed [ble_pkg::VALUE_W-1:0]   back_value;

    modport source (output valid, output status, output element_count,
                    output front_value, output back_value, input ready);
    modport sink (input valid, input status, input element_count,
                  input front_value, input back_value, output ready);
endinterface
`default_nettype wire

// File: src/bounded_list_engine_top.sv
// Bounded ordered list engine: the list lives in a circular buffer memory.
//
// The elements sit in a circular buffer of CAPACITY words with a head pointer, held in
// one synchronous memory with a registered read. Inserts at either end, deletes on a list
// of at most one element, rejected requests and unused action codes go from ST_IDLE
// straight to ST_FINISH; other deletes pass through ST_WAIT, since the new end element
// is read back from the memory. An insert strictly inside the list moves the elements
// behind it one place toward the back, one memory read and one write per cycle.
// A request is taken only while no other is in progress; the response register lets the
// next request start while a finished response still waits to be taken, and a request
// that finishes while that register is still full waits in its last cycle until the
// register is free. No clearing pass is needed after reset.
`default_nettype none
`include "bounded_list_engine_top_assert.svh"
module bounded_list_engine_top #(
    parameter int CAPACITY   = ble_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ble_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ble_req_if.sink    req,
    ble_rsp_if.source  rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > ble_pkg::POSITION_W) ? CW : ble_pkg::POSITION_W) + 1;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(CAPACITY - 1)) ? '0 : AW'(a + 1'b1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(CAPACITY - 1) : AW'(a - 1'b1);
    endfunction

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW + 1)'(a) + (CW + 1)'(b);
        if (s >= (CW + 1)'(CAPACITY))
        begin
            s = s - (CW + 1)'(CAPACITY);
        end
        return AW'(s);
    endfunction

    logic signed [DATA_WIDTH-1:0] mem [CAPACITY];
    logic signed [DATA_WIDTH-1:0] rdata_reg;

    ble_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic signed [DATA_WIDTH-1:0] front_reg, front_next;
    logic signed [DATA_WIDTH-1:0] back_reg, back_next;
    ble_pkg::status_t status_reg, status_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [AW-1:0] ins_reg, ins_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic pend_reg, pend_next;
    logic signed [DATA_WIDTH-1:0] val_reg, val_next;
    logic sel_front_reg, sel_front_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic [ble_pkg::STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [ble_pkg::COUNT_W-1:0] rsp_count_reg, rsp_count_next;
    logic signed [ble_pkg::VALUE_W-1:0] rsp_front_reg, rsp_front_next;
    logic signed [ble_pkg::VALUE_W-1:0] rsp_back_reg, rsp_back_next;

    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic signed [DATA_WIDTH-1:0] mem_wdata;
    logic mem_re;
    logic [AW-1:0] mem_raddr;

    ble_pkg::action_t act;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic is_ins;
    logic is_del;
    logic bad_pos;
    logic full;
    logic [CW-1:0] ins_idx;
    logic ins_ok;
    logic del_ok;
    logic ins_mid;
    logic slot_free;
    logic signed [DATA_WIDTH-1:0] din;
    ble_pkg::status_t req_status;

    // Request decode.
    always_comb
    begin
        act     = ble_pkg::action_t'(req.action);
        pos_ext = PW'(req.position);
        cnt_ext = PW'(count_reg);
        din     = DATA_WIDTH'(req.value);
        full    = (count_reg == CW'(CAPACITY));
        is_ins  = 1'b0;
        is_del  = 1'b0;
        bad_pos = 1'b0;
        ins_idx = '0;
        case (act)
            ble_pkg::ACT_INS_FRONT:
            begin
                is_ins = 1'b1;
            end
            ble_pkg::ACT_INS_BACK:
            begin
                is_ins  = 1'b1;
                ins_idx = count_reg;
            end
            ble_pkg::ACT_INS_POS:
            begin
                is_ins  = 1'b1;
                bad_pos = (pos_ext == '0) || (pos_ext > (cnt_ext + 1'b1));
                ins_idx = CW'(pos_ext - 1'b1);
            end
            ble_pkg::ACT_DEL_FRONT, ble_pkg::ACT_DEL_BACK:
            begin
                is_del = 1'b1;
            end
            default:
            begin
                is_ins = 1'b0;
            end
        endcase
        ins_ok  = is_ins && !bad_pos && !full;
        del_ok  = is_del && (count_reg != '0);
        ins_mid = (ins_idx != '0) && (ins_idx != count_reg);
        if (is_ins && bad_pos)
        begin
            req_status = ble_pkg::STAT_BADPOS;
        end
        else if (is_ins && full)
        begin
            req_status = ble_pkg::STAT_FULL;
        end
        else if (is_del && (count_reg == '0))
        begin
            req_status = ble_pkg::STAT_EMPTY;
        end
        else
        begin
            req_status = ble_pkg::STAT_OK;
        end
        slot_free = !rsp_valid_reg || rsp.ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ble_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (ins_ok && ins_mid)
                    begin
                        state_next = ble_pkg::ST_SHIFT;
                    end
                    else if (del_ok && (count_reg > CW'(1)))
                    begin
                        state_next = ble_pkg::ST_WAIT;
                    end
                    else
                    begin
                        state_next = ble_pkg::ST_FINISH;
                    end
                end
            end
            ble_pkg::ST_SHIFT:
            begin
                if ((rem_reg == '0) && !pend_reg)
                begin
                    state_next = ble_pkg::ST_FINISH;
                end
            end
            ble_pkg::ST_WAIT:
            begin
                state_next = ble_pkg::ST_FINISH;
            end
            ble_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ble_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ble_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and response register.
    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        status_next     = status_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        ins_next        = ins_reg;
        rem_next        = rem_reg;
        pend_next       = pend_reg;
        val_next        = val_reg;
        sel_front_next  = sel_front_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_front_next  = rsp_front_reg;
        rsp_back_next   = rsp_back_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = din;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        case (state_reg)
            ble_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    status_next = req_status;
                    val_next    = din;
                    if (ins_ok && (ins_idx == '0))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = wrap_dec(head_reg);
                        head_next  = wrap_dec(head_reg);
                        count_next = count_reg + 1'b1;
                        front_next = din;
                        if (count_reg == '0)
                        begin
                            back_next = din;
                        end
                    end
                    else if (ins_ok && (ins_idx == count_reg))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = wrap_add(head_reg, count_reg);
                        count_next = count_reg + 1'b1;
                        back_next  = din;
                    end
                    else if (ins_ok)
                    begin
                        src_next  = wrap_add(head_reg, count_reg - 1'b1);
                        ins_next  = wrap_add(head_reg, ins_idx);
                        rem_next  = count_reg - ins_idx;
                        pend_next = 1'b0;
                    end
                    else if (del_ok && (act == ble_pkg::ACT_DEL_FRONT))
                    begin
                        head_next      = wrap_inc(head_reg);
                        count_next     = count_reg - 1'b1;
                        mem_re         = 1'b1;
                        mem_raddr      = wrap_inc(head_reg);
                        sel_front_next = 1'b1;
                    end
                    else if (del_ok)
                    begin
                        count_next     = count_reg - 1'b1;
                        mem_re         = 1'b1;
                        mem_raddr      = wrap_add(head_reg, count_reg - CW'(2));
                        sel_front_next = 1'b0;
                    end
                end
            end
            ble_pkg::ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = rdata_reg;
                end
                if (rem_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = src_reg;
                    src_next  = wrap_dec(src_reg);
                    dst_next  = wrap_inc(src_reg);
                    pend_next = 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = ins_reg;
                        mem_wdata  = val_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ble_pkg::ST_WAIT:
            begin
                if (sel_front_reg)
                begin
                    front_next = rdata_reg;
                end
                else
                begin
                    back_next = rdata_reg;
                end
            end
            ble_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_count_next  = ble_pkg::COUNT_W'(count_reg);
                    if (count_reg == '0)
                    begin
                        rsp_front_next = '0;
                        rsp_back_next  = '0;
                    end
                    else
                    begin
                        rsp_front_next = ble_pkg::VALUE_W'(front_reg);
                        rsp_back_next  = ble_pkg::VALUE_W'(back_reg);
                    end
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ble_pkg::ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            sel_front_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ble_pkg::STAT_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            sel_front_reg <= sel_front_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        ins_reg        <= ins_next;
        val_reg        <= val_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_front_reg  <= rsp_front_next;
        rsp_back_reg   <= rsp_back_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign req.ready         = (state_reg == ble_pkg::ST_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.element_count = rsp_count_reg;
    assign rsp.front_value   = rsp_front_reg;
    assign rsp.back_value    = rsp_back_reg;

    `BLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY),
        "Element count exceeds capacity.")
    `BLE_ASSERT_NOW(a_head_bound, 1'b1, head_reg <= AW'(CAPACITY - 1),
        "Head pointer outside the buffer.")
    `BLE_ASSERT_NOW(a_shift_count, state_reg == ble_pkg::ST_SHIFT,
        (count_reg >= CW'(2)) && (count_reg < CW'(CAPACITY)),
        "Inner insert started on a list that is too short or full.")
    `BLE_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready,
        "A new request was taken while one is in progress.")

endmodule
`default_nettype wire

// File: dv/tb_bounded_list_engine_top.sv
// Testbench of the bounded list engine: directed and random requests, checked against a list model.
`default_nettype none
module tb_bounded_list_engine_top;
    import ble_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 100;

    typedef struct packed {
        logic        [ACTION_W-1:0]   action;
        logic signed [VALUE_W-1:0]    value;
        logic        [POSITION_W-1:0] position;
    } list_req_t;

    typedef struct packed {
        status_t                   status;
        logic        [COUNT_W-1:0] count;
        logic signed [VALUE_W-1:0] front;
        logic signed [VALUE_W-1:0] back;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    ble_req_if req_ch ();
    ble_rsp_if rsp_ch ();

    bounded_list_engine_top #(
        .CAPACITY   (LIST_CAP),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_req_t                 pending_req[$];
    list_rsp_t                 expected_rsp[$];
    logic signed [VALUE_W-1:0] list_image[$];
    int                        planned_count;
    int                        send_idle_pct;
    int                        recv_idle_pct;
    bit                        hold_go;
    logic                      rsp_hold;
    int                        mismatches;
    int                        accepted_reqs;
    int                        checked_rsps;
    int                        peak_count;
    int                        status_seen[4];

    function automatic list_rsp_t apply_list_request(input list_req_t r);
        list_rsp_t res;
        int        slot;
        res.status = STAT_OK;
        slot = 0;
        if (r.action == ACT_INS_FRONT || r.action == ACT_INS_BACK || r.action == ACT_INS_POS)
        begin
            if (r.action == ACT_INS_BACK)
            begin
                slot = list_image.size();
            end
            else if (r.action == ACT_INS_POS)
            begin
                if (r.position == 0 || r.position > list_image.size() + 1)
                    res.status = STAT_BADPOS;
                else
                    slot = r.position - 1;
            end
            if (res.status == STAT_OK)
            begin
                if (list_image.size() >= LIST_CAP)
                    res.status = STAT_FULL;
                else if (slot == list_image.size())
                    list_image.push_back(r.value);
                else
                    list_image.insert(slot, r.value);
            end
        end
        else if (r.action == ACT_DEL_FRONT || r.action == ACT_DEL_BACK)
        begin
            if (list_image.size() == 0)
                res.status = STAT_EMPTY;
            else if (r.action == ACT_DEL_FRONT)
                void'(list_image.pop_front());
            else
                void'(list_image.pop_back());
        end
        res.count = COUNT_W'(list_image.size());
        if (list_image.size() > 0)
        begin
            res.front = list_image[0];
            res.back  = list_image[$];
        end
        else
        begin
            res.front = '0;
            res.back  = '0;
        end
        if (list_image.size() > peak_count)
            peak_count = list_image.size();
        return res;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            4, 5:    return VALUE_W'($signed($urandom_range(0, 200)) - 100);
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // The planned count follows the list length so that positions can be aimed at it.
    task automatic push_req(input logic [ACTION_W-1:0] act, input logic signed [VALUE_W-1:0] val,
                            input logic [POSITION_W-1:0] pos);
        list_req_t r;
        r.action   = act;
        r.value    = val;
        r.position = pos;
        pending_req.push_back(r);
        if (act == ACT_INS_FRONT || act == ACT_INS_BACK)
        begin
            if (planned_count < LIST_CAP)
                planned_count++;
        end
        else if (act == ACT_INS_POS)
        begin
            if (pos >= 1 && pos <= planned_count + 1 && planned_count < LIST_CAP)
                planned_count++;
        end
        else if (act == ACT_DEL_FRONT || act == ACT_DEL_BACK)
        begin
            if (planned_count > 0)
                planned_count--;
        end
    endtask

    task automatic queue_segment(input int n, input int insert_pct);
        int                    k;
        logic [ACTION_W-1:0]   act;
        logic [POSITION_W-1:0] pos;
        for (k = 0; k < n; k++)
        begin
            pos = POSITION_W'($urandom_range(0, 127));
            if ($urandom_range(0, 99) < 3)
            begin
                act = ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
            end
            else if ($urandom_range(0, 99) < insert_pct)
            begin
                act = ACTION_W'($urandom_range(ACT_INS_FRONT, ACT_INS_POS));
                if (act == ACT_INS_POS)
                begin
                    if ($urandom_range(0, 99) < 85)
                        pos = POSITION_W'($urandom_range(1, planned_count + 1));
                    else if ($urandom_range(0, 1) == 1)
                        pos = '0;
                    else
                        pos = POSITION_W'($urandom_range(planned_count + 2, 127));
                end
            end
            else
            begin
                act = ACTION_W'($urandom_range(ACT_DEL_FRONT, ACT_DEL_BACK));
            end
            push_req(act, pick_value(), pos);
        end
    endtask

    task automatic wait_drained();
        while (!(pending_req.size() == 0 && !req_ch.valid && expected_rsp.size() == 0))
            @(negedge clk);
    endtask

    // Each phase fills the list past capacity, mixes, then drains it past empty.
    task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (with_hold)
            hold_go = 1'b1;
        queue_segment(100, 92);
        queue_segment(20, 50);
        queue_segment(100, 8);
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #3000000;
        $display("tb_bounded_list_engine_top NOT OK");
        $finish;
    end

    initial
    begin : receiver_hold
        rsp_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.action   <= '0;
            req_ch.value    <= '0;
            req_ch.position <= '0;
        end
        else
        begin : req_driver
            list_req_t nxt;
            if (req_ch.valid && req_ch.ready)
            begin
                nxt.action   = req_ch.action;
                nxt.value    = req_ch.value;
                nxt.position = req_ch.position;
                expected_rsp.push_back(apply_list_request(nxt));
                accepted_reqs++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_req.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_req.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.action   <= nxt.action;
                    req_ch.value    <= nxt.value;
                    req_ch.position <= nxt.position;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin : rsp_monitor
            list_rsp_t want;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("Response arrived with no request outstanding.");
                    mismatches++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    checked_rsps++;
                    status_seen[want.status]++;
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.element_count !== want.count)
                    begin
                        $error("element_count: expected %0d, got %0d", want.count,
                               rsp_ch.element_count);
                        mismatches++;
                    end
                    if (rsp_ch.front_value !== want.front)
                    begin
                        $error("front_value: expected %0d, got %0d", want.front,
                               rsp_ch.front_value);
                        mismatches++;
                    end
                    if (rsp_ch.back_value !== want.back)
                    begin
                        $error("back_value: expected %0d, got %0d", want.back,
                               rsp_ch.back_value);
                        mismatches++;
                    end
                end
            end
            rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        planned_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b0;
        mismatches = 0;
        accepted_reqs = 0;
        checked_rsps = 0;
        peak_count = 0;
        status_seen = '{default: 0};
        @(posedge rst_n);
        @(negedge clk);

        // Empty list, bad positions, both ends, the middle, and unused actions.
        push_req(ACT_DEL_FRONT, pick_value(), 7'd0);
        push_req(ACT_DEL_BACK, pick_value(), 7'd127);
        push_req(ACT_INS_POS, 32'sd11, 7'd0);
        push_req(ACT_INS_POS, 32'sd12, 7'd2);
        push_req(ACT_INS_POS, 32'sd5, 7'd1);
        push_req(ACT_INS_FRONT, 32'sh7fff_ffff, 7'd0);
        push_req(ACT_INS_BACK, 32'sh8000_0000, 7'd0);
        push_req(ACT_INS_POS, -32'sd1, 7'd4);
        push_req(ACT_INS_POS, 32'sd0, 7'd2);
        push_req(ACT_INS_POS, 32'sd13, 7'd127);
        push_req(ACT_INS_POS, 32'sd14, 7'd64);
        push_req(ACT_UNUSED_FIRST, 32'sd15, 7'd1);
        push_req(ACT_UNUSED_FIRST + 3'd1, 32'sd16, 7'd1);
        push_req(ACT_UNUSED_LAST, -32'sd17, 7'd127);
        push_req(ACT_DEL_FRONT, pick_value(), 7'd0);
        push_req(ACT_DEL_BACK, pick_value(), 7'd0);
        push_req(ACT_INS_POS, 32'sh5555_5555, 7'd3);
        push_req(ACT_DEL_FRONT, pick_value(), 7'd0);
        push_req(ACT_DEL_FRONT, pick_value(), 7'd0);
        push_req(ACT_DEL_BACK, pick_value(), 7'd0);
        push_req(ACT_DEL_BACK, pick_value(), 7'd0);
        push_req(ACT_DEL_BACK, pick_value(), 7'd0);
        push_req(ACT_INS_BACK, 32'shaaaa_aaaa, 7'd0);
        push_req(ACT_DEL_FRONT, pick_value(), 7'd0);
        wait_drained();

        run_phase(6, 85, 1'b0);
        run_phase(85, 6, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests and checked %0d responses, peak list length %0d.",
                 accepted_reqs, checked_rsps, peak_count);
        $display("Statuses seen: ok %0d, bad position %0d, full %0d, empty %0d.",
                 status_seen[STAT_OK], status_seen[STAT_BADPOS], status_seen[STAT_FULL],
                 status_seen[STAT_EMPTY]);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("tb_bounded_list_engine_top OK");
        else
            $display("tb_bounded_list_engine_top NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
